// ===== src/lrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsp_pkg
// Shared types and constants of the log record slot pointer: flash geometry,
// field widths, command and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package lrsp_pkg;

	// flash geometry
	localparam int SECTORS          = 4096;
	localparam int PAGES_PER_SECTOR = 16;
	localparam int PAGE_BYTES       = 256;
	localparam int RECORD_BYTES     = 20;
	localparam int MAX_READ         = 20;

	localparam int SLOTS_PER_PAGE = PAGE_BYTES / RECORD_BYTES;
	localparam int PAD_BYTES      = PAGE_BYTES - SLOTS_PER_PAGE * RECORD_BYTES;
	localparam int SLOT_GAP       = RECORD_BYTES + PAD_BYTES;

	// field widths
	localparam int CMD_W    = 2;
	localparam int COUNT_W  = 8;
	localparam int ADDR_W   = 25;
	localparam int STATUS_W = 2;
	localparam int PAGE_W   = 5;
	localparam int SLOT_W   = 4;
	localparam int NUM_W    = 5;

	localparam int OFF_W      = $clog2(PAGE_BYTES);
	localparam int SEC_PAGE_W = (PAGES_PER_SECTOR > 1) ? $clog2(PAGES_PER_SECTOR) : 1;
	localparam int LEFT_W     = $clog2(MAX_READ + 1);

	localparam logic [ADDR_W-1:0] END_ADDR =
		ADDR_W'(SECTORS * PAGES_PER_SECTOR * PAGE_BYTES);

	// command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic walk_emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_start;
		logic walk_fin;
	} dp_stat_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] idx;
	} slot_dec_t;

	// slot index of a page offset, ok only on a slot start
	function automatic slot_dec_t slot_of_offset(input logic [OFF_W-1:0] off);
		slot_dec_t r;
		r.ok  = 1'b0;
		r.idx = '0;
		for (int k = 0; k < SLOTS_PER_PAGE; k++) begin
			if (off == OFF_W'(k * RECORD_BYTES)) begin
				r.ok  = 1'b1;
				r.idx = SLOT_W'(k);
			end
		end
		return r;
	endfunction

endpackage

// ===== src/lrsp_in_if.sv =====
// ----------------------------------------------------------------------------
// lrsp_in_if
// Command channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface lrsp_in_if;
	logic                           valid;
	logic                           ready;
	logic [lrsp_pkg::CMD_W-1:0]     cmd;
	logic [lrsp_pkg::COUNT_W-1:0]   count;
	logic [lrsp_pkg::ADDR_W-1:0]    load_address;

	modport source (output valid, output cmd, output count, output load_address,
		input ready);
	modport sink (input valid, input cmd, input count, input load_address,
		output ready);
endinterface

// ===== src/lrsp_out_if.sv =====
// ----------------------------------------------------------------------------
// lrsp_out_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface lrsp_out_if;
	logic                            valid;
	logic                            ready;
	logic [lrsp_pkg::STATUS_W-1:0]   status;
	logic [lrsp_pkg::ADDR_W-1:0]     address;
	logic [lrsp_pkg::PAGE_W-1:0]     page;
	logic [lrsp_pkg::SLOT_W-1:0]     slot;
	logic                            record_valid;
	logic [lrsp_pkg::NUM_W-1:0]      record_number;
	logic                            last;

	modport source (output valid, output status, output address, output page,
		output slot, output record_valid, output record_number, output last,
		input ready);
	modport sink (input valid, input status, input address, input page,
		input slot, input record_valid, input record_number, input last,
		output ready);
endinterface

// ===== src/lrsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrsp_ctrl
// Controller: idle/walk state machine, input ready, and result valid flag.
// ----------------------------------------------------------------------------
module lrsp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  lrsp_pkg::dp_stat_t   stat,
	output lrsp_pkg::ctrl_cmd_t  ctl
);

	lrsp_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrsp_pkg::S_IDLE: begin
				if (ctl.take && stat.walk_start) begin
					state_d = lrsp_pkg::S_WALK;
				end
			end
			lrsp_pkg::S_WALK: begin
				if (out_free && stat.walk_fin) begin
					state_d = lrsp_pkg::S_IDLE;
				end
			end
			default: state_d = lrsp_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		ctl.take      = 1'b0;
		ctl.walk_emit = 1'b0;
		unique case (state_q)
			lrsp_pkg::S_IDLE: begin
				in_ready = out_free;
				ctl.take = in_valid && out_free;
			end
			lrsp_pkg::S_WALK: begin
				ctl.walk_emit = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrsp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((ctl.take && !stat.walk_start) || ctl.walk_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/lrsp_dp.sv =====
// ----------------------------------------------------------------------------
// lrsp_dp
// Datapath: write pointer, backward walk position and result register.
// ----------------------------------------------------------------------------
module lrsp_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lrsp_pkg::ctrl_cmd_t              ctl,
	output lrsp_pkg::dp_stat_t               stat,
	input  logic [lrsp_pkg::CMD_W-1:0]       cmd,
	input  logic [lrsp_pkg::COUNT_W-1:0]     count,
	input  logic [lrsp_pkg::ADDR_W-1:0]      load_address,
	output logic [lrsp_pkg::STATUS_W-1:0]    status,
	output logic [lrsp_pkg::ADDR_W-1:0]      address,
	output logic [lrsp_pkg::PAGE_W-1:0]      page,
	output logic [lrsp_pkg::SLOT_W-1:0]      slot,
	output logic                             record_valid,
	output logic [lrsp_pkg::NUM_W-1:0]       record_number,
	output logic                             last
);

	localparam int AW = lrsp_pkg::ADDR_W;
	localparam int PW = lrsp_pkg::PAGE_W;
	localparam int SW = lrsp_pkg::SLOT_W;
	localparam int LW = lrsp_pkg::LEFT_W;
	localparam int NW = lrsp_pkg::NUM_W;

	localparam logic [AW-1:0] REC_A  = AW'(lrsp_pkg::RECORD_BYTES);
	localparam logic [AW-1:0] GAP_A  = AW'(lrsp_pkg::SLOT_GAP);
	localparam logic [PW-1:0] PAGES  = PW'(lrsp_pkg::PAGES_PER_SECTOR);
	localparam logic [SW-1:0] SLOTS  = SW'(lrsp_pkg::SLOTS_PER_PAGE);
	localparam logic [PW-1:0] PG_TOP = PW'(lrsp_pkg::PAGES_PER_SECTOR - 1);
	localparam logic [SW-1:0] SL_TOP = SW'(lrsp_pkg::SLOTS_PER_PAGE - 1);
	localparam logic [LW-1:0] MAXR   = LW'(lrsp_pkg::MAX_READ);

	// write pointer and walk position
	logic [AW-1:0] next_addr_q, next_addr_d;
	logic [PW-1:0] next_page_q, next_page_d;
	logic [SW-1:0] next_slot_q, next_slot_d;
	logic [AW-1:0] walk_addr_q, walk_addr_d;
	logic [PW-1:0] walk_page_q, walk_page_d;
	logic [SW-1:0] walk_slot_q, walk_slot_d;
	logic [LW-1:0] walk_left_q, walk_left_d;
	logic [NW-1:0] walk_num_q, walk_num_d;

	// result register
	logic [lrsp_pkg::STATUS_W-1:0] res_status_q, res_status_d;
	logic [AW-1:0] res_addr_q, res_addr_d;
	logic [PW-1:0] res_page_q, res_page_d;
	logic [SW-1:0] res_slot_q, res_slot_d;
	logic          res_valid_q, res_valid_d;
	logic [NW-1:0] res_num_q, res_num_d;
	logic          res_last_q, res_last_d;
	logic          res_load;

	logic          full;
	logic          empty;
	logic [AW-1:0] add_rec, add_gap;
	logic [AW-1:0] back_addr;
	logic [PW-1:0] back_page;
	logic [SW-1:0] back_slot;
	logic [AW-1:0] sb_addr;
	logic [PW-1:0] sb_page;
	logic [SW-1:0] sb_slot;
	logic [LW-1:0] clamp_n;
	lrsp_pkg::slot_dec_t dec;

	assign full    = next_addr_q >= lrsp_pkg::END_ADDR;
	assign empty   = next_addr_q == '0;
	assign add_rec = next_addr_q + REC_A;
	assign add_gap = next_addr_q + GAP_A;
	assign dec     = lrsp_pkg::slot_of_offset(load_address[lrsp_pkg::OFF_W-1:0]);
	assign clamp_n = (count > lrsp_pkg::COUNT_W'(lrsp_pkg::MAX_READ)) ? MAXR
		: LW'(count);

	assign stat.walk_start = (cmd == lrsp_pkg::CMD_READ) && (count != '0) && !empty;
	assign stat.walk_fin   = (walk_left_q == LW'(1)) || (walk_addr_q == '0);

	// one step back from a position: walk source is the walk or the pointer
	always_comb begin
		if (ctl.walk_emit) begin
			sb_addr = walk_addr_q;
			sb_page = walk_page_q;
			sb_slot = walk_slot_q;
		end else begin
			sb_addr = next_addr_q;
			sb_page = next_page_q;
			sb_slot = next_slot_q;
		end
		if (sb_slot != '0) begin
			back_addr = (sb_addr >= REC_A) ? sb_addr - REC_A : '0;
			back_page = sb_page;
			back_slot = sb_slot - SW'(1);
		end else begin
			back_addr = (sb_addr >= GAP_A) ? sb_addr - GAP_A : '0;
			back_page = (sb_page != '0) ? sb_page - PW'(1) : PG_TOP;
			back_slot = SL_TOP;
		end
	end

	always_comb begin
		next_addr_d  = next_addr_q;
		next_page_d  = next_page_q;
		next_slot_d  = next_slot_q;
		walk_addr_d  = walk_addr_q;
		walk_page_d  = walk_page_q;
		walk_slot_d  = walk_slot_q;
		walk_left_d  = walk_left_q;
		walk_num_d   = walk_num_q;
		res_load     = 1'b0;
		res_status_d = lrsp_pkg::ST_OK;
		res_addr_d   = next_addr_q;
		res_page_d   = next_page_q;
		res_slot_d   = next_slot_q;
		res_valid_d  = 1'b0;
		res_num_d    = '0;
		res_last_d   = 1'b1;

		if (ctl.take) begin
			res_load = 1'b1;
			case (cmd)
				lrsp_pkg::CMD_WRITE: begin
					if (full) begin
						res_status_d = lrsp_pkg::ST_FULL;
					end else begin
						res_valid_d = 1'b1;
						if (next_slot_q < SL_TOP) begin
							next_addr_d = add_rec;
							next_slot_d = next_slot_q + SW'(1);
						end else if (next_page_q < PG_TOP) begin
							next_addr_d = add_gap;
							next_page_d = next_page_q + PW'(1);
							next_slot_d = '0;
						end else if (add_gap >= lrsp_pkg::END_ADDR) begin
							next_addr_d  = lrsp_pkg::END_ADDR;
							next_page_d  = PAGES;
							next_slot_d  = SLOTS;
							res_status_d = lrsp_pkg::ST_FULL;
						end else begin
							next_addr_d = add_gap;
							next_page_d = '0;
							next_slot_d = '0;
						end
					end
				end
				lrsp_pkg::CMD_READ: begin
					if (count == '0) begin
						res_status_d = lrsp_pkg::ST_INVALID;
					end else if (empty) begin
						res_addr_d  = '0;
						res_page_d  = '0;
						res_slot_d  = '0;
						walk_left_d = '0;
					end else begin
						res_load    = 1'b0;
						walk_left_d = clamp_n;
						walk_num_d  = NW'(1);
						if (full) begin
							walk_addr_d = lrsp_pkg::END_ADDR - GAP_A;
							walk_page_d = PG_TOP;
							walk_slot_d = SL_TOP;
						end else begin
							walk_addr_d = back_addr;
							walk_page_d = back_page;
							walk_slot_d = back_slot;
						end
					end
				end
				lrsp_pkg::CMD_LOAD: begin
					if (load_address >= lrsp_pkg::END_ADDR) begin
						next_addr_d  = lrsp_pkg::END_ADDR;
						next_page_d  = PAGES;
						next_slot_d  = SLOTS;
						res_addr_d   = lrsp_pkg::END_ADDR;
						res_page_d   = PAGES;
						res_slot_d   = SLOTS;
						res_status_d = lrsp_pkg::ST_FULL;
					end else if (!dec.ok) begin
						res_status_d = lrsp_pkg::ST_INVALID;
					end else begin
						next_addr_d = load_address;
						next_page_d = PW'(load_address[lrsp_pkg::OFF_W +: lrsp_pkg::SEC_PAGE_W]
							& lrsp_pkg::SEC_PAGE_W'(lrsp_pkg::PAGES_PER_SECTOR - 1));
						next_slot_d = dec.idx;
						res_addr_d  = load_address;
						res_page_d  = next_page_d;
						res_slot_d  = dec.idx;
					end
				end
				default: begin
					res_status_d = lrsp_pkg::ST_INVALID;
				end
			endcase
		end else if (ctl.walk_emit) begin
			res_load     = 1'b1;
			res_addr_d   = walk_addr_q;
			res_page_d   = walk_page_q;
			res_slot_d   = walk_slot_q;
			res_valid_d  = 1'b1;
			res_num_d    = walk_num_q;
			res_last_d   = stat.walk_fin;
			walk_num_d   = walk_num_q + NW'(1);
			if (stat.walk_fin) begin
				walk_left_d = '0;
			end else begin
				walk_left_d = walk_left_q - LW'(1);
				walk_addr_d = back_addr;
				walk_page_d = back_page;
				walk_slot_d = back_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_addr_q <= '0;
			next_page_q <= '0;
			next_slot_q <= '0;
			walk_addr_q <= '0;
			walk_page_q <= '0;
			walk_slot_q <= '0;
			walk_left_q <= '0;
			walk_num_q  <= '0;
		end else begin
			next_addr_q <= next_addr_d;
			next_page_q <= next_page_d;
			next_slot_q <= next_slot_d;
			walk_addr_q <= walk_addr_d;
			walk_page_q <= walk_page_d;
			walk_slot_q <= walk_slot_d;
			walk_left_q <= walk_left_d;
			walk_num_q  <= walk_num_d;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= res_status_d;
			res_addr_q   <= res_addr_d;
			res_page_q   <= res_page_d;
			res_slot_q   <= res_slot_d;
			res_valid_q  <= res_valid_d;
			res_num_q    <= res_num_d;
			res_last_q   <= res_last_d;
		end
	end

	assign status        = res_status_q;
	assign address       = res_addr_q;
	assign page          = res_page_q;
	assign slot          = res_slot_q;
	assign record_valid  = res_valid_q;
	assign record_number = res_num_q;
	assign last          = res_last_q;

endmodule

// ===== src/log_record_slot_pointer.sv =====
// ----------------------------------------------------------------------------
// log_record_slot_pointer
// Next write position of an append-only record log in serial flash: hands
// out slot addresses, lists the newest records, and loads the pointer.
//
//   channel   dir  beat contents
//   cmd_ch    in   cmd, count, load_address
//   res_ch    out  status, address, page, slot, record_valid,
//                  record_number, last
//
// write, load, zero-count or empty-log read and unused codes: one result beat.
// a read of n records (at most MAX_READ): a set-up step, then n beats, one a
// cycle while res_ch is not stalled; fewer if the walk reaches address 0 first.
// reset clears the pointer to an empty log; no start-up pass.
// the result register holds while res_ch is stalled; cmd_ch is not ready
// during a read walk or while an untaken result blocks the register.
// ----------------------------------------------------------------------------
module log_record_slot_pointer (
	input  logic         clk,
	input  logic         arst_n,
	lrsp_in_if.sink      cmd_ch,
	lrsp_out_if.source   res_ch
);

	lrsp_pkg::ctrl_cmd_t ctl;
	lrsp_pkg::dp_stat_t  stat;

	lrsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_ch.valid),
		.in_ready  (cmd_ch.ready),
		.out_valid (res_ch.valid),
		.out_ready (res_ch.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	lrsp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd_ch.cmd),
		.count         (cmd_ch.count),
		.load_address  (cmd_ch.load_address),
		.status        (res_ch.status),
		.address       (res_ch.address),
		.page          (res_ch.page),
		.slot          (res_ch.slot),
		.record_valid  (res_ch.record_valid),
		.record_number (res_ch.record_number),
		.last          (res_ch.last)
	);

`ifndef SYNTHESIS
	a_no_take_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_emit |-> !cmd_ch.ready)
		else $error("command taken during read walk");

	a_fin_sets_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_emit && stat.walk_fin |=> res_ch.valid && res_ch.last)
		else $error("final walk beat without last");

	a_num_has_record: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.record_number != '0 |-> res_ch.record_valid)
		else $error("record number on a beat with no record");
`endif

endmodule

// ===== dv/log_record_slot_pointer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// log_record_slot_pointer_tb
// Self-checking bench for the flash log slot pointer. A queue-fed driver
// sends write, read, load and unused commands. A monitor predicts every
// result beat from its own model of the pointer and walk. Results are
// checked in order, under four idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
module log_record_slot_pointer_tb;

	localparam logic [lrsp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 8;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 25;
	localparam int RANDOM_ITEMS = 49;
	localparam int ADDR_TOP     = (1 << lrsp_pkg::ADDR_W) - 1;

	typedef struct {
		logic [lrsp_pkg::CMD_W-1:0]   cmd;
		logic [lrsp_pkg::COUNT_W-1:0] count;
		logic [lrsp_pkg::ADDR_W-1:0]  load_address;
	} cmd_beat_t;

	typedef struct packed {
		lrsp_pkg::status_t            status;
		logic [lrsp_pkg::ADDR_W-1:0]  address;
		logic [lrsp_pkg::PAGE_W-1:0]  page;
		logic [lrsp_pkg::SLOT_W-1:0]  slot;
		logic                         record_valid;
		logic [lrsp_pkg::NUM_W-1:0]   record_number;
		logic                         last;
	} result_beat_t;

	logic clk;
	logic arst_n;

	lrsp_in_if  cmd_if ();
	lrsp_out_if res_if ();

	log_record_slot_pointer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_if),
		.res_ch (res_if)
	);

	cmd_beat_t    pending_cmds[$];
	result_beat_t results_due[$];
	cmd_beat_t    drive_beat;
	cmd_beat_t    seen_beat;
	result_beat_t want, got;

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int quiet_cycles;

	// pointer model
	logic [lrsp_pkg::ADDR_W-1:0] ptr_addr;
	logic [lrsp_pkg::PAGE_W-1:0] ptr_page;
	logic [lrsp_pkg::SLOT_W-1:0] ptr_slot;
	logic [lrsp_pkg::ADDR_W-1:0] walk_addr;
	logic [lrsp_pkg::PAGE_W-1:0] walk_page;
	logic [lrsp_pkg::SLOT_W-1:0] walk_slot;
	logic [lrsp_pkg::NUM_W-1:0]  walk_left;

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	function automatic void push_result(lrsp_pkg::status_t st,
		logic [lrsp_pkg::ADDR_W-1:0] a, logic [lrsp_pkg::PAGE_W-1:0] p,
		logic [lrsp_pkg::SLOT_W-1:0] s, logic v, logic [lrsp_pkg::NUM_W-1:0] num,
		logic fin);
		result_beat_t r;
		r.status        = st;
		r.address       = a;
		r.page          = p;
		r.slot          = s;
		r.record_valid  = v;
		r.record_number = num;
		r.last          = fin;
		results_due.push_back(r);
	endfunction

	function automatic void echo_pointer(lrsp_pkg::status_t st);
		push_result(st, ptr_addr, ptr_page, ptr_slot, 1'b0, '0, 1'b1);
	endfunction

	function automatic void set_full();
		ptr_addr = lrsp_pkg::END_ADDR;
		ptr_page = lrsp_pkg::PAGE_W'(lrsp_pkg::PAGES_PER_SECTOR);
		ptr_slot = lrsp_pkg::SLOT_W'(lrsp_pkg::SLOTS_PER_PAGE);
	endfunction

	function automatic void walk_back();
		if (walk_slot > 0) begin
			walk_addr = (walk_addr >= lrsp_pkg::ADDR_W'(lrsp_pkg::RECORD_BYTES)) ?
				walk_addr - lrsp_pkg::ADDR_W'(lrsp_pkg::RECORD_BYTES) : '0;
			walk_slot = walk_slot - 1'b1;
		end else begin
			walk_addr = (walk_addr >= lrsp_pkg::ADDR_W'(lrsp_pkg::SLOT_GAP)) ?
				walk_addr - lrsp_pkg::ADDR_W'(lrsp_pkg::SLOT_GAP) : '0;
			walk_page = (walk_page > 0) ? walk_page - 1'b1 :
				lrsp_pkg::PAGE_W'(lrsp_pkg::PAGES_PER_SECTOR - 1);
			walk_slot = lrsp_pkg::SLOT_W'(lrsp_pkg::SLOTS_PER_PAGE - 1);
		end
	endfunction

	function automatic void predict_results(cmd_beat_t b);
		lrsp_pkg::status_t           st;
		logic [lrsp_pkg::ADDR_W-1:0] a;
		logic [lrsp_pkg::PAGE_W-1:0] p;
		logic [lrsp_pkg::SLOT_W-1:0] s;
		logic [lrsp_pkg::NUM_W-1:0]  num;
		logic                        fin;
		int unsigned                 n, off, idx;
		case (b.cmd)
			lrsp_pkg::CMD_WRITE: begin
				if (ptr_addr >= lrsp_pkg::END_ADDR) begin
					echo_pointer(lrsp_pkg::ST_FULL);
				end else begin
					st = lrsp_pkg::ST_OK;
					a  = ptr_addr;
					p  = ptr_page;
					s  = ptr_slot;
					if (ptr_slot + 1 < lrsp_pkg::SLOTS_PER_PAGE) begin
						ptr_addr = ptr_addr + lrsp_pkg::ADDR_W'(lrsp_pkg::RECORD_BYTES);
						ptr_slot = ptr_slot + 1'b1;
					end else if (ptr_page + 1 < lrsp_pkg::PAGES_PER_SECTOR) begin
						ptr_addr = ptr_addr + lrsp_pkg::ADDR_W'(lrsp_pkg::SLOT_GAP);
						ptr_page = ptr_page + 1'b1;
						ptr_slot = '0;
					end else begin
						ptr_addr = ptr_addr + lrsp_pkg::ADDR_W'(lrsp_pkg::SLOT_GAP);
						if (ptr_addr >= lrsp_pkg::END_ADDR) begin
							set_full();
							st = lrsp_pkg::ST_FULL;
						end else begin
							ptr_page = '0;
							ptr_slot = '0;
						end
					end
					push_result(st, a, p, s, 1'b1, '0, 1'b1);
				end
			end
			lrsp_pkg::CMD_READ: begin
				n = b.count;
				if (n == 0) begin
					echo_pointer(lrsp_pkg::ST_INVALID);
				end else if (ptr_addr == '0) begin
					walk_left = '0;
					push_result(lrsp_pkg::ST_OK, '0, '0, '0, 1'b0, '0, 1'b1);
				end else begin
					if (n > lrsp_pkg::MAX_READ)
						n = lrsp_pkg::MAX_READ;
					if (ptr_addr >= lrsp_pkg::END_ADDR) begin
						walk_addr = lrsp_pkg::END_ADDR - lrsp_pkg::ADDR_W'(lrsp_pkg::SLOT_GAP);
						walk_page = lrsp_pkg::PAGE_W'(lrsp_pkg::PAGES_PER_SECTOR - 1);
						walk_slot = lrsp_pkg::SLOT_W'(lrsp_pkg::SLOTS_PER_PAGE - 1);
					end else begin
						walk_addr = ptr_addr;
						walk_page = ptr_page;
						walk_slot = ptr_slot;
						walk_back();
					end
					walk_left = lrsp_pkg::NUM_W'(n);
					num = '0;
					while (walk_left != 0) begin
						num = num + 1'b1;
						walk_left = walk_left - 1'b1;
						fin = (walk_left == 0) || (walk_addr == '0);
						push_result(lrsp_pkg::ST_OK, walk_addr, walk_page, walk_slot, 1'b1,
							num, fin);
						if (fin)
							walk_left = '0;
						else
							walk_back();
					end
				end
			end
			lrsp_pkg::CMD_LOAD: begin
				if (b.load_address >= lrsp_pkg::END_ADDR) begin
					set_full();
					echo_pointer(lrsp_pkg::ST_FULL);
				end else begin
					off = b.load_address % lrsp_pkg::PAGE_BYTES;
					idx = off / lrsp_pkg::RECORD_BYTES;
					if ((off % lrsp_pkg::RECORD_BYTES) != 0 || idx >= lrsp_pkg::SLOTS_PER_PAGE) begin
						echo_pointer(lrsp_pkg::ST_INVALID);
					end else begin
						ptr_addr = b.load_address;
						ptr_page = lrsp_pkg::PAGE_W'((b.load_address / lrsp_pkg::PAGE_BYTES)
							% lrsp_pkg::PAGES_PER_SECTOR);
						ptr_slot = lrsp_pkg::SLOT_W'(idx);
						echo_pointer(lrsp_pkg::ST_OK);
					end
				end
			end
			default: begin
				echo_pointer(lrsp_pkg::ST_INVALID);
			end
		endcase
	endfunction

	function automatic logic [lrsp_pkg::ADDR_W-1:0] slot_address(int sector, int pg, int sl);
		return lrsp_pkg::ADDR_W'(sector * lrsp_pkg::PAGES_PER_SECTOR * lrsp_pkg::PAGE_BYTES
			+ pg * lrsp_pkg::PAGE_BYTES + sl * lrsp_pkg::RECORD_BYTES);
	endfunction

	function automatic void queue_cmd(logic [lrsp_pkg::CMD_W-1:0] c, int cnt,
		logic [lrsp_pkg::ADDR_W-1:0] a);
		cmd_beat_t b;
		b.cmd          = c;
		b.count        = lrsp_pkg::COUNT_W'(cnt);
		b.load_address = a;
		pending_cmds.push_back(b);
	endfunction

	function automatic void queue_random_cmd();
		cmd_beat_t b;
		int        pick, sector;
		b.cmd          = lrsp_pkg::CMD_WRITE;
		b.count        = lrsp_pkg::COUNT_W'($urandom());
		b.load_address = lrsp_pkg::ADDR_W'($urandom());
		pick = $urandom_range(99);
		if (pick < 35) begin
			b.cmd = lrsp_pkg::CMD_WRITE;
		end else if (pick < 65) begin
			b.cmd = lrsp_pkg::CMD_READ;
			if ($urandom_range(99) < 80)
				b.count = lrsp_pkg::COUNT_W'($urandom_range(25, 1));
		end else if (pick < 93) begin
			b.cmd = lrsp_pkg::CMD_LOAD;
			pick = $urandom_range(99);
			if (pick < 65) begin
				case ($urandom_range(2))
					0: sector = lrsp_pkg::SECTORS - 1;
					1: sector = $urandom_range(1);
					default: sector = $urandom_range(lrsp_pkg::SECTORS - 1);
				endcase
				b.load_address = slot_address(sector,
					$urandom_range(lrsp_pkg::PAGES_PER_SECTOR - 1),
					$urandom_range(lrsp_pkg::SLOTS_PER_PAGE - 1));
			end else if (pick < 80) begin
				b.load_address = lrsp_pkg::ADDR_W'($urandom_range(ADDR_TOP,
					int'(lrsp_pkg::END_ADDR)));
			end
		end else begin
			b.cmd = CMD_UNUSED;
		end
		pending_cmds.push_back(b);
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || cmd_if.valid || results_due.size() != 0)
			@(posedge clk);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid        <= 1'b0;
			cmd_if.cmd          <= '0;
			cmd_if.count        <= '0;
			cmd_if.load_address <= '0;
		end else if (!cmd_if.valid || cmd_if.ready) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_beat = pending_cmds.pop_front();
				cmd_if.valid        <= 1'b1;
				cmd_if.cmd          <= drive_beat.cmd;
				cmd_if.count        <= drive_beat.count;
				cmd_if.load_address <= drive_beat.load_address;
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_if.ready <= 1'b0;
		else
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
			mismatches   = 0;
			ptr_addr     = '0;
			ptr_page     = '0;
			ptr_slot     = '0;
			walk_addr    = '0;
			walk_page    = '0;
			walk_slot    = '0;
			walk_left    = '0;
		end else begin
			if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (cmd_if.valid && cmd_if.ready) begin
				seen_beat.cmd          = cmd_if.cmd;
				seen_beat.count        = cmd_if.count;
				seen_beat.load_address = cmd_if.load_address;
				predict_results(seen_beat);
			end
			if (res_if.valid && res_if.ready) begin
				got.status        = lrsp_pkg::status_t'(res_if.status);
				got.address       = res_if.address;
				got.page          = res_if.page;
				got.slot          = res_if.slot;
				got.record_valid  = res_if.record_valid;
				got.record_number = res_if.record_number;
				got.last          = res_if.last;
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: st=%0d addr=%0d pg=%0d sl=%0d",
							got.status, got.address, got.page, got.slot,
							" v=%0d n=%0d l=%0d",
							got.record_valid, got.record_number, got.last);
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status || got.address !== want.address
						|| got.page !== want.page || got.slot !== want.slot
						|| got.record_valid !== want.record_valid
						|| got.record_number !== want.record_number
						|| got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch exp: st=%0d addr=%0d pg=%0d sl=%0d v=%0d n=%0d l=%0d",
								want.status, want.address, want.page, want.slot,
								want.record_valid, want.record_number, want.last);
							$display("         got: st=%0d addr=%0d pg=%0d sl=%0d v=%0d n=%0d l=%0d",
								got.status, got.address, got.page, got.slot,
								got.record_valid, got.record_number, got.last);
						end
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		queue_cmd(lrsp_pkg::CMD_READ, 5, '0);
		queue_cmd(lrsp_pkg::CMD_WRITE, 0, '0);
		queue_cmd(lrsp_pkg::CMD_WRITE, 0, '0);
		queue_cmd(lrsp_pkg::CMD_READ, 0, '0);
		queue_cmd(lrsp_pkg::CMD_READ, 255, '0);
		queue_cmd(CMD_UNUSED, 0, '0);
		queue_cmd(lrsp_pkg::CMD_LOAD, 0,
			lrsp_pkg::ADDR_W'(lrsp_pkg::SLOTS_PER_PAGE * lrsp_pkg::RECORD_BYTES));
		queue_cmd(lrsp_pkg::CMD_LOAD, 0, lrsp_pkg::ADDR_W'(lrsp_pkg::RECORD_BYTES + 1));
		queue_cmd(lrsp_pkg::CMD_LOAD, 0, slot_address(0, 0, lrsp_pkg::SLOTS_PER_PAGE - 1));
		queue_cmd(lrsp_pkg::CMD_WRITE, 0, '0);
		queue_cmd(lrsp_pkg::CMD_WRITE, 0, '0);
		queue_cmd(lrsp_pkg::CMD_LOAD, 0, slot_address(0, lrsp_pkg::PAGES_PER_SECTOR - 1,
			lrsp_pkg::SLOTS_PER_PAGE - 1));
		queue_cmd(lrsp_pkg::CMD_WRITE, 0, '0);
		queue_cmd(lrsp_pkg::CMD_WRITE, 0, '0);
		queue_cmd(lrsp_pkg::CMD_READ, 3, '0);
		queue_cmd(lrsp_pkg::CMD_READ, lrsp_pkg::MAX_READ + 1, '0);
		queue_cmd(lrsp_pkg::CMD_LOAD, 0,
			lrsp_pkg::END_ADDR - lrsp_pkg::ADDR_W'(lrsp_pkg::SLOT_GAP));
		queue_cmd(lrsp_pkg::CMD_WRITE, 0, '0);
		queue_cmd(lrsp_pkg::CMD_WRITE, 0, '0);
		queue_cmd(lrsp_pkg::CMD_READ, lrsp_pkg::MAX_READ, '0);
		queue_cmd(lrsp_pkg::CMD_LOAD, 0, lrsp_pkg::ADDR_W'(ADDR_TOP));
		queue_cmd(lrsp_pkg::CMD_LOAD, 0, lrsp_pkg::END_ADDR);
		queue_cmd(lrsp_pkg::CMD_LOAD, 0, '0);
		queue_cmd(lrsp_pkg::CMD_READ, 1, '0);
		queue_cmd(lrsp_pkg::CMD_LOAD, 0, lrsp_pkg::ADDR_W'(2 * lrsp_pkg::RECORD_BYTES));
		queue_cmd(lrsp_pkg::CMD_READ, lrsp_pkg::MAX_READ, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			for (int i = 0; i < RANDOM_ITEMS; i++)
				queue_random_cmd();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
